>>> design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// invariant on every clock edge out of reset
`define FSIM_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("invariant failed");

// same-cycle implication
`define FSIM_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("implication failed");

// next-cycle implication
`define FSIM_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

>>> design/fsim_pkg.sv
package fsim_pkg;

    localparam int MAX_JOBS     = 32;
    localparam int MAX_MACHINES = 16;
    localparam int TIME_BITS    = 16;
    localparam int SPAN_W       = 22;

    localparam int MACH_W = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
    localparam int DEPTH  = MAX_JOBS * MAX_MACHINES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int JCNT_W = $clog2(MAX_JOBS + 1);
    localparam int MCNT_W = $clog2(MAX_MACHINES + 1);

    localparam int MC_REG_W = 5;
    localparam int SL_REG_W = 6;
    localparam int CFG_W    = 6;
    localparam int TIME_W   = 16;
    localparam int POS_W    = 6;

    localparam logic CFG_MACHINE_COUNT   = 1'b0;
    localparam logic CFG_SEQUENCE_LENGTH = 1'b1;

    typedef enum logic [2:0] {
        S_LOAD, S_H_RD, S_H_EX, S_T_RD, S_T_EX, S_I_RD, S_I_EX, S_EMIT
    } t_state;

    typedef enum logic [1:0] {OP_NONE, OP_HEAD, OP_TAIL, OP_INS} t_op;

    typedef struct packed {
        logic                 seq_we;
        logic                 cand_we;
        logic [ADDR_W-1:0]    ld_addr;
        logic [MACH_W-1:0]    ld_mach;
        logic [TIME_BITS-1:0] ld_time;
        t_op                  op;
        logic [JCNT_W-1:0]    j;
        logic [MCNT_W-1:0]    i;
        logic                 edge_m;
        logic                 row_zero;
        logic                 k_first;
        logic                 k_last;
        logic                 emit;
        logic                 emit_last;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

    function automatic logic [ADDR_W-1:0] addr(input logic [JCNT_W-1:0] j,
                                               input logic [MCNT_W-1:0] i);
        return ADDR_W'(ADDR_W'(j) * ADDR_W'(MAX_MACHINES) + ADDR_W'(i));
    endfunction

    function automatic logic [SPAN_W-1:0] sat_add(input logic [SPAN_W-1:0] a,
                                                  input logic [SPAN_W-1:0] b);
        logic [SPAN_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SPAN_W] ? {SPAN_W{1'b1}} : s[SPAN_W-1:0];
    endfunction

    function automatic logic [SPAN_W-1:0] max2(input logic [SPAN_W-1:0] a,
                                               input logic [SPAN_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

endpackage

>>> design/fsim_ctrl.sv
module fsim_ctrl
    import fsim_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [CFG_W-1:0]    i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_is_candidate,
    input  logic                i_start_of_set,
    input  logic [TIME_W-1:0]   i_proc_time,
    input  t_sts                i_sts,
    output t_cmd                o_cmd
);

    t_state              r_state, n_state;
    logic [MC_REG_W-1:0] r_mc_reg;
    logic [SL_REG_W-1:0] r_sl_reg;
    logic [JCNT_W-1:0]   r_jc, n_jc, r_cj, n_cj;
    logic [MCNT_W-1:0]   r_mc, n_mc, r_ci, n_ci;

    logic [MCNT_W-1:0]   m_eff, m_last, mc_eff, mc_inc;
    logic [JCNT_W-1:0]   n_eff, n_last, jc_eff;
    logic                acc, cand_done;

    always_comb begin
        if (r_mc_reg == '0) begin
            m_eff = MCNT_W'(1);
        end else if (32'(r_mc_reg) > MAX_MACHINES) begin
            m_eff = MCNT_W'(MAX_MACHINES);
        end else begin
            m_eff = MCNT_W'(r_mc_reg);
        end
        if (r_sl_reg == '0) begin
            n_eff = JCNT_W'(1);
        end else if (32'(r_sl_reg) > MAX_JOBS) begin
            n_eff = JCNT_W'(MAX_JOBS);
        end else begin
            n_eff = JCNT_W'(r_sl_reg);
        end
        m_last = m_eff - MCNT_W'(1);
        n_last = n_eff - JCNT_W'(1);
    end

    assign o_in_stall = (r_state != S_LOAD);
    assign acc        = i_in_valid && (r_state == S_LOAD);

    always_comb begin
        mc_eff = i_start_of_set ? '0 : r_mc;
        if (mc_eff >= m_eff) begin
            mc_eff = '0;
        end
        jc_eff    = i_start_of_set ? '0 : r_jc;
        mc_inc    = mc_eff + MCNT_W'(1);
        cand_done = acc && i_is_candidate && (mc_inc == m_eff);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (cand_done) begin
                    n_state = S_H_RD;
                end
            end
            S_H_RD: n_state = S_H_EX;
            S_H_EX: begin
                n_state = (r_ci == m_last && r_cj == n_last) ? S_T_RD : S_H_RD;
            end
            S_T_RD: n_state = S_T_EX;
            S_T_EX: begin
                n_state = (r_ci == '0 && r_cj == '0) ? S_I_RD : S_T_RD;
            end
            S_I_RD: n_state = S_I_EX;
            S_I_EX: n_state = (r_ci == m_last) ? S_EMIT : S_I_RD;
            S_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = (r_cj == n_eff) ? S_LOAD : S_I_RD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // outputs and counters
    always_comb begin
        n_jc = r_jc;
        n_mc = r_mc;
        n_cj = r_cj;
        n_ci = r_ci;

        o_cmd           = '0;
        o_cmd.op        = OP_NONE;
        o_cmd.ld_addr   = addr(jc_eff, mc_eff);
        o_cmd.ld_mach   = mc_eff[MACH_W-1:0];
        o_cmd.ld_time   = i_proc_time[TIME_BITS-1:0];
        o_cmd.j         = r_cj;
        o_cmd.i         = r_ci;
        o_cmd.k_first   = (r_cj == '0);
        o_cmd.k_last    = (r_cj == n_eff);
        o_cmd.emit_last = (r_cj == n_eff);

        unique case (r_state)
            S_LOAD: begin
                if (acc) begin
                    n_jc = jc_eff;
                    n_mc = mc_eff;
                    if (!i_is_candidate) begin
                        if (jc_eff < n_eff) begin
                            o_cmd.seq_we = 1'b1;
                            if (mc_inc == m_eff) begin
                                n_mc = '0;
                                n_jc = jc_eff + JCNT_W'(1);
                            end else begin
                                n_mc = mc_inc;
                            end
                        end
                    end else begin
                        o_cmd.cand_we = 1'b1;
                        if (cand_done) begin
                            n_mc = '0;
                            n_cj = '0;
                            n_ci = '0;
                        end else begin
                            n_mc = mc_inc;
                        end
                    end
                end
            end
            S_H_RD, S_T_RD, S_I_RD: begin
            end
            S_H_EX: begin
                o_cmd.op       = OP_HEAD;
                o_cmd.edge_m   = (r_ci == '0);
                o_cmd.row_zero = (r_cj == '0);
                if (r_ci == m_last) begin
                    if (r_cj == n_last) begin
                        n_ci = m_last;
                    end else begin
                        n_ci = '0;
                        n_cj = r_cj + JCNT_W'(1);
                    end
                end else begin
                    n_ci = r_ci + MCNT_W'(1);
                end
            end
            S_T_EX: begin
                o_cmd.op       = OP_TAIL;
                o_cmd.edge_m   = (r_ci == m_last);
                o_cmd.row_zero = (r_cj == n_last);
                if (r_ci == '0) begin
                    if (r_cj != '0) begin
                        n_ci = m_last;
                        n_cj = r_cj - JCNT_W'(1);
                    end
                end else begin
                    n_ci = r_ci - MCNT_W'(1);
                end
            end
            S_I_EX: begin
                o_cmd.op     = OP_INS;
                o_cmd.edge_m = (r_ci == '0);
                if (r_ci != m_last) begin
                    n_ci = r_ci + MCNT_W'(1);
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_ci       = '0;
                    if (r_cj != n_eff) begin
                        n_cj = r_cj + JCNT_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_mc_reg <= MC_REG_W'(1);
            r_sl_reg <= SL_REG_W'(1);
            r_jc     <= '0;
            r_mc     <= '0;
            r_cj     <= '0;
            r_ci     <= '0;
        end else begin
            r_state <= n_state;
            r_jc    <= n_jc;
            r_mc    <= n_mc;
            r_cj    <= n_cj;
            r_ci    <= n_ci;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_MACHINE_COUNT) begin
                    r_mc_reg <= i_cfg_data[MC_REG_W-1:0];
                end
                if (i_cfg_idx == CFG_SEQUENCE_LENGTH) begin
                    r_sl_reg <= i_cfg_data[SL_REG_W-1:0];
                end
            end
        end
    end

`include "assert_macros.svh"

    `FSIM_NEXT(a_cand_done_starts, cand_done, r_state == S_H_RD)
    `FSIM_IMPL(a_emit_needs_room, o_cmd.emit, i_sts.out_free && r_state == S_EMIT)

endmodule

>>> design/fsim_dp.sv
module fsim_dp
    import fsim_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [POS_W-1:0]  o_position,
    output logic [SPAN_W-1:0] o_makespan,
    output logic              o_last_of_run
);

    logic [TIME_BITS-1:0] seq_mem  [DEPTH];
    logic [SPAN_W-1:0]    head_mem [DEPTH];
    logic [SPAN_W-1:0]    tail_mem [DEPTH];
    logic [TIME_BITS-1:0] r_cand   [MAX_MACHINES];
    logic [SPAN_W-1:0]    r_row    [MAX_MACHINES];

    logic [TIME_BITS-1:0] r_seq_rd;
    logic [SPAN_W-1:0]    r_head_rd, r_tail_rd, r_run, r_best;
    logic                 r_o_valid;
    logic [POS_W-1:0]     r_pos;
    logic [SPAN_W-1:0]    r_span;
    logic                 r_last;

    logic [ADDR_W-1:0]    rd_addr, prev_addr;
    logic [MACH_W-1:0]    mi;
    logic [SPAN_W-1:0]    prev_row, prev_run, val, e_in, q_in, f_val, best_val;

    assign rd_addr   = addr(i_cmd.j, i_cmd.i);
    assign prev_addr = addr(i_cmd.j - JCNT_W'(1), i_cmd.i);
    assign mi        = i_cmd.i[MACH_W-1:0];

    always_comb begin
        prev_row = i_cmd.row_zero ? '0 : r_row[mi];
        prev_run = i_cmd.edge_m ? '0 : r_run;
        val      = sat_add(max2(prev_row, prev_run), SPAN_W'(r_seq_rd));
        e_in     = i_cmd.k_first ? '0 : r_head_rd;
        q_in     = i_cmd.k_last ? '0 : r_tail_rd;
        f_val    = sat_add(max2(prev_run, e_in), SPAN_W'(r_cand[mi]));
        best_val = max2(i_cmd.edge_m ? '0 : r_best, sat_add(f_val, q_in));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.seq_we) begin
            seq_mem[i_cmd.ld_addr] <= i_cmd.ld_time;
        end
        r_seq_rd <= seq_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_HEAD) begin
            head_mem[rd_addr] <= val;
        end
        r_head_rd <= head_mem[prev_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_TAIL) begin
            tail_mem[rd_addr] <= val;
        end
        r_tail_rd <= tail_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cand_we) begin
            r_cand[i_cmd.ld_mach] <= i_cmd.ld_time;
        end
        if (i_cmd.op == OP_HEAD || i_cmd.op == OP_TAIL) begin
            r_row[mi] <= val;
            r_run     <= val;
        end
        if (i_cmd.op == OP_INS) begin
            r_run  <= f_val;
            r_best <= best_val;
        end
        if (i_cmd.emit) begin
            r_pos  <= POS_W'(i_cmd.j);
            r_span <= r_best;
            r_last <= i_cmd.emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    assign o_sts.out_free = !r_o_valid || !i_out_stall;
    assign o_out_valid    = r_o_valid;
    assign o_position     = r_pos;
    assign o_makespan     = r_span;
    assign o_last_of_run  = r_last;

`include "assert_macros.svh"

    `FSIM_NEXT(a_emit_sets_valid, i_cmd.emit, r_o_valid)

endmodule

>>> design/flow_shop_insertion_makespan_core.sv
// channel  direction  handshake                 word
// in       input      i_in_valid / o_in_stall   is_candidate, start_of_set, proc_time
// out      output     o_out_valid / i_out_stall position, makespan, last_of_run
// cfg      input      i_cfg_we                  i_cfg_idx, i_cfg_data
//
// Loads take one word per cycle while o_in_stall is low. The last candidate word starts a pass
// that computes heads, then tails, then the makespan of each of the n+1 insertion positions;
// each matrix element has a read state and then an update state on the memories.
// Synchronous active-low reset; the final result waits in the output register
// while new words are taken. A stalled output holds the next position back.
module flow_shop_insertion_makespan_core
    import fsim_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_is_candidate,
    input  logic              i_start_of_set,
    input  logic [TIME_W-1:0] i_proc_time,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [POS_W-1:0]  o_position,
    output logic [SPAN_W-1:0] o_makespan,
    output logic              o_last_of_run
);

    t_cmd cmd;
    t_sts sts;

    fsim_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_is_candidate (i_is_candidate),
        .i_start_of_set (i_start_of_set),
        .i_proc_time    (i_proc_time),
        .i_sts          (sts),
        .o_cmd          (cmd)
    );

    fsim_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_position    (o_position),
        .o_makespan    (o_makespan),
        .o_last_of_run (o_last_of_run)
    );

endmodule

>>> bench/flow_shop_insertion_makespan_checker.sv
`timescale 1ns / 1ps
module flow_shop_insertion_makespan_checker
    import fsim_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic              i_is_candidate,
    input  logic              i_start_of_set,
    input  logic [TIME_W-1:0] i_proc_time,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [POS_W-1:0]  i_position,
    input  logic [SPAN_W-1:0] i_makespan,
    input  logic              i_last_of_run,
    output int                o_fail_count,
    output int                o_pending
);
    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic [SPAN_W-1:0] makespan;
        logic              last_of_run;
    } t_span_result;

    t_span_result span_q[$];
    logic [MC_REG_W-1:0] mach_reg;
    logic [SL_REG_W-1:0] len_reg;
    logic [TIME_BITS-1:0] seq_t[DEPTH];
    logic [SPAN_W-1:0] heads[DEPTH];
    logic [SPAN_W-1:0] tails[DEPTH];
    logic [TIME_BITS-1:0] cand_t[MAX_MACHINES];
    int jobs_loaded;
    int mach_pos;
    int fails;

    assign o_fail_count = fails;
    assign o_pending = span_q.size();

    function automatic logic [SPAN_W-1:0] clip_add(longint a, longint b);
        longint s;
        s = a + b;
        return (s > 64'h3FFFFF) ? {SPAN_W{1'b1}} : SPAN_W'(s);
    endfunction

    function automatic longint larger(longint a, longint b);
        return a > b ? a : b;
    endfunction

    task automatic predict_insertions(int n, int m);
        longint f, best, e, q, lft, up;
        t_span_result r;
        for (int j = 0; j < n; j++)
            for (int i = 0; i < m; i++) begin
                lft = j > 0 ? heads[(j-1)*MAX_MACHINES+i] : 0;
                up = i > 0 ? heads[j*MAX_MACHINES+i-1] : 0;
                heads[j*MAX_MACHINES+i] = clip_add(larger(lft, up), seq_t[j*MAX_MACHINES+i]);
            end
        for (int j = n - 1; j >= 0; j--)
            for (int i = m - 1; i >= 0; i--) begin
                lft = j < n - 1 ? tails[(j+1)*MAX_MACHINES+i] : 0;
                up = i < m - 1 ? tails[j*MAX_MACHINES+i+1] : 0;
                tails[j*MAX_MACHINES+i] = clip_add(larger(lft, up), seq_t[j*MAX_MACHINES+i]);
            end
        for (int k = 0; k <= n; k++) begin
            f = 0;
            best = 0;
            for (int i = 0; i < m; i++) begin
                e = k > 0 ? heads[(k-1)*MAX_MACHINES+i] : 0;
                q = k < n ? tails[k*MAX_MACHINES+i] : 0;
                f = clip_add(larger(f, e), cand_t[i]);
                best = larger(best, clip_add(f, q));
            end
            r.position = POS_W'(k);
            r.makespan = SPAN_W'(best);
            r.last_of_run = (k == n);
            span_q.insert(span_q.size(), r);
        end
    endtask

    always @(posedge i_clk) begin
        int m, n;
        t_span_result exp_r;
        if (!i_rst_n) begin
            mach_reg <= 1;
            len_reg <= 1;
            jobs_loaded = 0;
            mach_pos = 0;
            fails = 0;
            span_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_MACHINE_COUNT) mach_reg <= i_cfg_data[MC_REG_W-1:0];
                else len_reg <= i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                m = mach_reg == 0 ? 1 : (mach_reg > MAX_MACHINES ? MAX_MACHINES : mach_reg);
                n = len_reg == 0 ? 1 : (len_reg > MAX_JOBS ? MAX_JOBS : len_reg);
                if (i_start_of_set) begin
                    jobs_loaded = 0;
                    mach_pos = 0;
                end
                if (mach_pos >= m) mach_pos = 0;
                if (!i_is_candidate) begin
                    if (jobs_loaded < n) begin
                        seq_t[jobs_loaded*MAX_MACHINES+mach_pos] = i_proc_time;
                        mach_pos++;
                        if (mach_pos == m) begin
                            mach_pos = 0;
                            jobs_loaded++;
                        end
                    end
                end else begin
                    cand_t[mach_pos] = i_proc_time;
                    mach_pos++;
                    if (mach_pos >= m) begin
                        mach_pos = 0;
                        predict_insertions(n, m);
                    end
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (span_q.size() == 0) begin
                    $error("unexpected result position=%0d makespan=%0d", i_position, i_makespan);
                    fails++;
                end else begin
                    exp_r = span_q.pop_front();
                    if (i_position !== exp_r.position) begin
                        $error("position exp %0d got %0d", exp_r.position, i_position);
                        fails++;
                    end
                    if (i_makespan !== exp_r.makespan) begin
                        $error("makespan exp %0d got %0d", exp_r.makespan, i_makespan);
                        fails++;
                    end
                    if (i_last_of_run !== exp_r.last_of_run) begin
                        $error("last_of_run exp %0d got %0d", exp_r.last_of_run, i_last_of_run);
                        fails++;
                    end
                end
            end
        end
    end
endmodule

>>> bench/flow_shop_insertion_makespan_core_tb.sv
`timescale 1ns / 1ps
module flow_shop_insertion_makespan_core_tb;
    import fsim_pkg::*;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic              i_cfg_idx;
    logic [CFG_W-1:0]  i_cfg_data;
    logic              i_in_valid;
    logic              o_in_stall;
    logic              i_is_candidate;
    logic              i_start_of_set;
    logic [TIME_W-1:0] i_proc_time;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [POS_W-1:0]  o_position;
    logic [SPAN_W-1:0] o_makespan;
    logic              o_last_of_run;
    int                fail_count;
    int                pending;
    int                words_sent;
    bit                hold_sink;
    bit                sink_quiet;

    flow_shop_insertion_makespan_core dut (.*);

    flow_shop_insertion_makespan_checker checker_i (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_in_valid, .i_in_stall(o_in_stall), .i_is_candidate, .i_start_of_set,
        .i_proc_time, .i_out_valid(o_out_valid), .i_out_stall,
        .i_position(o_position), .i_makespan(o_makespan), .i_last_of_run(o_last_of_run),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("FAIL");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 4);
    endfunction

    function automatic logic [TIME_W-1:0] pick_time(int mode);
        case (mode)
            0: return TIME_W'($urandom_range(20));
            1: return TIME_W'($urandom_range(65535, 65000));
            default: return TIME_W'($urandom);
        endcase
    endfunction

    initial begin
        i_out_stall = 1;
        @(posedge i_clk);
        forever begin
            if (hold_sink) begin
                i_out_stall <= 1;
                @(posedge i_clk);
            end else if (!sink_quiet && $urandom_range(99) < 30) begin
                i_out_stall <= 1;
                repeat (pick_gap() + 1) @(posedge i_clk);
            end else begin
                i_out_stall <= 0;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        hold_sink = 0;
        sink_quiet = 0;
        wait (words_sent >= 150);
        hold_sink = 1;
        repeat (600) @(posedge i_clk);
        hold_sink = 0;
        wait (words_sent >= 260);
        sink_quiet = 1;
        wait (words_sent >= 300);
        sink_quiet = 0;
    end

    task automatic send_word(bit cand, bit sos, logic [TIME_W-1:0] t, bit gaps);
        int g;
        g = gaps ? pick_gap() : 0;
        if (g > 0) begin
            i_in_valid <= 0;
            repeat (g) @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_is_candidate <= cand;
        i_start_of_set <= sos;
        i_proc_time <= t;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, int value);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= CFG_W'(value);
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic run_problem(int n, int m, int mode, bit gaps, int cands);
        for (int j = 0; j < n; j++)
            for (int i = 0; i < m; i++)
                send_word(0, j == 0 && i == 0, pick_time(mode), gaps);
        for (int c = 0; c < cands; c++)
            for (int i = 0; i < m; i++)
                send_word(1, i == 0 && (c == 0 || $urandom_range(1)), pick_time(mode), gaps);
    endtask

    initial begin
        int n, m, r;
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_idx = 0;
        i_cfg_data = 0;
        i_in_valid = 0;
        i_is_candidate = 0;
        i_start_of_set = 0;
        i_proc_time = 0;
        words_sent = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // reset configuration: one job, one machine
        send_word(0, 1, 16'd0, 0);
        send_word(1, 1, 16'hFFFF, 0);
        send_word(0, 0, 16'h1234, 0);
        send_word(1, 0, 16'h0, 0);
        drain();
        write_reg(CFG_MACHINE_COUNT, 16);
        write_reg(CFG_SEQUENCE_LENGTH, 1);
        run_problem(1, 16, 1, 0, 1);
        drain();
        write_reg(CFG_MACHINE_COUNT, 0);
        write_reg(CFG_SEQUENCE_LENGTH, 63);
        run_problem(32, 1, 1, 0, 1);
        drain();
        write_reg(CFG_MACHINE_COUNT, 31);
        write_reg(CFG_SEQUENCE_LENGTH, 0);
        run_problem(1, 16, 0, 0, 1);
        drain();
        // shrink machines so the counter reaches the new count
        write_reg(CFG_MACHINE_COUNT, 3);
        write_reg(CFG_SEQUENCE_LENGTH, 2);
        send_word(0, 1, 16'd5, 0);
        send_word(0, 0, 16'd5, 0);
        send_word(0, 0, 16'd5, 0);
        send_word(0, 0, 16'd7, 0);
        send_word(0, 0, 16'd9, 0);
        send_word(0, 0, 16'd1, 0);
        send_word(0, 0, 16'hAAAA, 0);
        send_word(1, 1, 16'd3, 0);
        send_word(1, 0, 16'h5555, 0);
        drain();
        write_reg(CFG_MACHINE_COUNT, 2);
        send_word(1, 0, 16'd4, 0);
        send_word(1, 0, 16'd4, 0);
        drain();

        while (words_sent < 320) begin
            r = $urandom_range(99);
            if (r < 8) m = 16; else m = $urandom_range(4, 1);
            if (r > 94) n = 32; else n = $urandom_range(4, 1);
            write_reg(CFG_MACHINE_COUNT, m);
            write_reg(CFG_SEQUENCE_LENGTH, n);
            if ($urandom_range(9) == 0)
                send_word(1'($urandom_range(1)), 1'($urandom_range(1)),
                          TIME_W'($urandom), 1);
            run_problem(n, m, $urandom_range(2), 1, $urandom_range(3, 1));
            if ($urandom_range(3) == 0)
                send_word(0, 0, TIME_W'($urandom), 1);
            drain();
        end

        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
